// ===== rtl/eucq_pkg.sv =====
// Shared types, constants and CORDIC arithmetic for the Euler-to-quaternion pipeline.
package eucq_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;

	localparam int FRAC_BITS = ANGLE_BITS - 3;
	localparam int TAB_SHIFT = 33 - ANGLE_BITS;
	localparam int IN_UP     = FRAC_BITS - 13;
	localparam int IN_DN     = (IN_UP < 0) ? -IN_UP : 1;

	localparam int AW       = ANGLE_BITS + 2;
	localparam int WW       = 36;
	localparam int MW       = 32;
	localparam int PW       = 64;
	localparam int SQ_STEPS = 31;
	localparam int SQW      = 62;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint ONE_Q30  = 64'sd1 <<< 30;
	localparam longint PI_Q30   = 64'sd3373259426;

	localparam longint ATAN_Q30 [32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001, 64'h00000000
	};

	function automatic longint to_ang(input longint v);
		return (v + (64'sd1 <<< (TAB_SHIFT - 1))) >>> TAB_SHIFT;
	endfunction

	localparam longint PI_ANG = to_ang(PI_Q30);
	localparam longint HP_ANG = to_ang(PI_Q30 / 2);

	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [WW-1:0] wq_t;
	typedef logic signed [MW-1:0] mul_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic        [SQW-1:0] sq_t;

	typedef struct packed {
		wq_t  x;
		wq_t  y;
		ang_t z;
	} rot_t;

	typedef struct packed {
		rot_t r;
		logic neg;
	} sc_t;

	typedef struct packed {
		rot_t r;
		logic zero;
	} at_t;

	typedef struct packed {
		sq_t v;
		sq_t r;
	} sqs_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} eucq_in_t;

	typedef struct packed {
		logic signed [15:0] q_w;
		logic signed [15:0] q_x;
		logic signed [15:0] q_y;
		logic signed [15:0] q_z;
	} eucq_out_t;

	function automatic ang_t atan_ang(input int i);
		return ang_t'(to_ang(ATAN_Q30[i]));
	endfunction

	function automatic ang_t in_ang(input logic signed [15:0] raw);
		longint v;
		v = longint'(raw);
		if (IN_UP >= 0) begin
			return ang_t'(v <<< IN_UP);
		end else begin
			return ang_t'((v + (64'sd1 <<< (IN_DN - 1))) >>> IN_DN);
		end
	endfunction

	// fold the angle into +-pi/2, remember to negate the result
	function automatic sc_t sc_pre(input ang_t a);
		sc_t s;
		s.r.x = wq_t'(GAIN_Q30);
		s.r.y = '0;
		s.r.z = a;
		s.neg = 1'b0;
		if (a > ang_t'(HP_ANG)) begin
			s.r.z = a - ang_t'(PI_ANG);
			s.neg = 1'b1;
		end else if (a < -ang_t'(HP_ANG)) begin
			s.r.z = a + ang_t'(PI_ANG);
			s.neg = 1'b1;
		end
		return s;
	endfunction

	function automatic sc_t sc_step(input sc_t s, input int i, input logic last);
		sc_t  r;
		wq_t  dx;
		wq_t  dy;
		ang_t t;
		dx = s.r.y >>> i;
		dy = s.r.x >>> i;
		t  = atan_ang(i);
		r.neg = s.neg;
		if (s.r.z >= 0) begin
			r.r.x = s.r.x - dx;
			r.r.y = s.r.y + dy;
			r.r.z = s.r.z - t;
		end else begin
			r.r.x = s.r.x + dx;
			r.r.y = s.r.y - dy;
			r.r.z = s.r.z + t;
		end
		if (last && s.neg) begin
			r.r.x = -r.r.x;
			r.r.y = -r.r.y;
		end
		return r;
	endfunction

	// pre-rotate a left-half vector by a quarter turn
	function automatic at_t at_pre(input wq_t y, input wq_t x);
		at_t a;
		a.zero = (x == 0) && (y == 0);
		a.r.x  = x;
		a.r.y  = y;
		a.r.z  = '0;
		if (x < 0) begin
			if (y >= 0) begin
				a.r.x = y;
				a.r.y = -x;
				a.r.z = ang_t'(HP_ANG);
			end else begin
				a.r.x = -y;
				a.r.y = x;
				a.r.z = -ang_t'(HP_ANG);
			end
		end
		return a;
	endfunction

	function automatic at_t at_step(input at_t s, input int i);
		at_t  r;
		wq_t  dx;
		wq_t  dy;
		ang_t t;
		dx = s.r.y >>> i;
		dy = s.r.x >>> i;
		t  = atan_ang(i);
		r.zero = s.zero;
		if (s.r.y < 0) begin
			r.r.x = s.r.x - dx;
			r.r.y = s.r.y + dy;
			r.r.z = s.r.z - t;
		end else begin
			r.r.x = s.r.x + dx;
			r.r.y = s.r.y - dy;
			r.r.z = s.r.z + t;
		end
		return r;
	endfunction

	function automatic sqs_t sq_step(input sqs_t s, input int k);
		sqs_t r;
		sq_t  b;
		sq_t  rb;
		b  = sq_t'(1) << (60 - 2 * k);
		rb = s.r + b;
		if (s.v >= rb) begin
			r.v = s.v - rb;
			r.r = (s.r >> 1) + b;
		end else begin
			r.v = s.v;
			r.r = s.r >> 1;
		end
		return r;
	endfunction

	function automatic prod_t mulw(input wq_t a, input wq_t b);
		mul_t a32;
		mul_t b32;
		a32 = a[MW-1:0];
		b32 = b[MW-1:0];
		return prod_t'(a32) * prod_t'(b32);
	endfunction

	function automatic wq_t rnd30(input prod_t p);
		prod_t t;
		t = p + (prod_t'(1) <<< 29);
		return wq_t'(t >>> 30);
	endfunction

	function automatic wq_t sat_one(input wq_t v);
		if (v > wq_t'(ONE_Q30)) begin
			return wq_t'(ONE_Q30);
		end else if (v < -wq_t'(ONE_Q30)) begin
			return -wq_t'(ONE_Q30);
		end
		return v;
	endfunction

	function automatic logic signed [15:0] out_q(input wq_t v);
		wq_t t;
		t = (v + (wq_t'(1) <<< 15)) >>> 16;
		if (t > wq_t'(16384)) begin
			t = wq_t'(16384);
		end else if (t < -wq_t'(16384)) begin
			t = -wq_t'(16384);
		end
		return t[15:0];
	endfunction

endpackage

// ===== rtl/euler_convention_to_quaternion_top.sv =====
// Throughput: one item per cycle while the output is not stalled; three CORDIC chains
// and a 31-step square root, one step a stage, set the depth, and every stage takes a new
// item each cycle unless the output stalls.
// A stalled output freezes the whole pipeline, input stall follows at once.
// Reset clears the valid bits only; datapath registers are not reset.
// Top level: fully pipelined Euler-to-quaternion datapath with valid/stall handshake.
module euler_convention_to_quaternion_top import eucq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      angles_valid,
	output logic      angles_stall,
	input  eucq_in_t  angles,
	output logic      quat_valid,
	input  logic      quat_stall,
	output eucq_out_t quat
);

	localparam int N   = CORDIC_STEPS;
	localparam int NST = 3 * N + 43;

	logic [NST-1:0] vld_q;
	logic           en;

	ang_t ang_in [3];
	ang_t half_ang [3];

	sc_t sc1_s [3][N+1];

	prod_t p_cpcr_s1, p_crsp_s1, p_cpsy_s1, p_cysp_s1, p_spsr_s1, p_cpcy_s1;
	wq_t   sr_s1, sy_s1;

	wq_t r33_s2, r31_s2, t1_s2, a_s2, b_s2, t2_s2, sr_s2, sy_s2;

	prod_t pa_s3, pb_s3, psq_s3;
	wq_t   r32_s3, r33_s3, r31_s3, t1_s3, t2_s3;

	sqs_t sq_s  [SQ_STEPS+1];
	wq_t  r32_s [SQ_STEPS+1];
	wq_t  r33_s [SQ_STEPS+1];
	wq_t  r31_s [SQ_STEPS+1];
	wq_t  r21_s [SQ_STEPS+1];
	wq_t  r11_s [SQ_STEPS+1];

	at_t at_s  [3][N+1];
	sc_t sc2_s [3][N+1];

	prod_t     fm_s1 [4];
	wq_t       cy_s1, sy2_s1;
	wq_t       fa_s2 [4];
	wq_t       cy_s2, sy2_s2;
	prod_t     fp_s3 [8];
	wq_t       fr_s4 [8];
	eucq_out_t out_s5;

	// hold everything while the result waits
	assign en           = !(vld_q[NST-1] && quat_stall);
	assign angles_stall = !en;
	assign quat_valid   = vld_q[NST-1];
	assign quat         = out_s5;

	assign ang_in[0] = in_ang(angles.roll_angle);
	assign ang_in[1] = in_ang(angles.pitch_angle);
	assign ang_in[2] = in_ang(angles.yaw_angle);

	// new angles: zero vector gives zero, pitch is negated, then halve
	always_comb begin
		ang_t z0;
		ang_t z1;
		ang_t z2;
		z0 = at_s[0][N].zero ? '0 : at_s[0][N].r.z;
		z1 = at_s[1][N].zero ? '0 : -at_s[1][N].r.z;
		z2 = at_s[2][N].zero ? '0 : at_s[2][N].r.z;
		half_ang[0] = z0 >>> 1;
		half_ang[1] = z1 >>> 1;
		half_ang[2] = z2 >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], angles_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// first sine/cosine chains
			for (int l = 0; l < 3; l++) begin
				sc1_s[l][0] <= sc_pre(ang_in[l]);
				for (int k = 0; k < N; k++) begin
					sc1_s[l][k+1] <= sc_step(sc1_s[l][k], k, k == N - 1);
				end
			end

			// rotation-matrix terms
			p_cpcr_s1 <= mulw(sc1_s[1][N].r.x, sc1_s[0][N].r.x);
			p_crsp_s1 <= mulw(sc1_s[0][N].r.x, sc1_s[1][N].r.y);
			p_cpsy_s1 <= mulw(sc1_s[1][N].r.x, sc1_s[2][N].r.y);
			p_cysp_s1 <= mulw(sc1_s[2][N].r.x, sc1_s[1][N].r.y);
			p_spsr_s1 <= mulw(sc1_s[1][N].r.y, sc1_s[0][N].r.y);
			p_cpcy_s1 <= mulw(sc1_s[1][N].r.x, sc1_s[2][N].r.x);
			sr_s1     <= sc1_s[0][N].r.y;
			sy_s1     <= sc1_s[2][N].r.y;

			r33_s2 <= rnd30(p_cpcr_s1);
			r31_s2 <= sat_one(rnd30(p_crsp_s1));
			t1_s2  <= rnd30(p_cpsy_s1);
			a_s2   <= rnd30(p_cysp_s1);
			b_s2   <= rnd30(p_spsr_s1);
			t2_s2  <= rnd30(p_cpcy_s1);
			sr_s2  <= sr_s1;
			sy_s2  <= sy_s1;

			pa_s3  <= mulw(a_s2, sr_s2);
			pb_s3  <= mulw(b_s2, sy_s2);
			psq_s3 <= mulw(r31_s2, r31_s2);
			r32_s3 <= sr_s2;
			r33_s3 <= r33_s2;
			r31_s3 <= r31_s2;
			t1_s3  <= t1_s2;
			t2_s3  <= t2_s2;

			r32_s[0]  <= r32_s3;
			r33_s[0]  <= r33_s3;
			r31_s[0]  <= r31_s3;
			r21_s[0]  <= -(t1_s3 + rnd30(pa_s3));
			r11_s[0]  <= t2_s3 - rnd30(pb_s3);
			sq_s[0].v <= sq_t'(ONE_Q30 * ONE_Q30) - sq_t'(psq_s3);
			sq_s[0].r <= '0;

			// square root, one result bit a stage
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_s[k+1]  <= sq_step(sq_s[k], k);
				r32_s[k+1] <= r32_s[k];
				r33_s[k+1] <= r33_s[k];
				r31_s[k+1] <= r31_s[k];
				r21_s[k+1] <= r21_s[k];
				r11_s[k+1] <= r11_s[k];
			end

			// atan2 chains
			at_s[0][0] <= at_pre(r32_s[SQ_STEPS], r33_s[SQ_STEPS]);
			at_s[1][0] <= at_pre(r31_s[SQ_STEPS], wq_t'(sq_s[SQ_STEPS].r[WW-1:0]));
			at_s[2][0] <= at_pre(r21_s[SQ_STEPS], r11_s[SQ_STEPS]);
			for (int l = 0; l < 3; l++) begin
				for (int k = 0; k < N; k++) begin
					at_s[l][k+1] <= at_step(at_s[l][k], k);
				end
			end

			// second sine/cosine chains on the half angles
			for (int l = 0; l < 3; l++) begin
				sc2_s[l][0] <= sc_pre(half_ang[l]);
				for (int k = 0; k < N; k++) begin
					sc2_s[l][k+1] <= sc_step(sc2_s[l][k], k, k == N - 1);
				end
			end

			// quaternion products
			fm_s1[0] <= mulw(sc2_s[0][N].r.x, sc2_s[1][N].r.x);
			fm_s1[1] <= mulw(sc2_s[0][N].r.y, sc2_s[1][N].r.y);
			fm_s1[2] <= mulw(sc2_s[0][N].r.y, sc2_s[1][N].r.x);
			fm_s1[3] <= mulw(sc2_s[0][N].r.x, sc2_s[1][N].r.y);
			cy_s1    <= sc2_s[2][N].r.x;
			sy2_s1   <= sc2_s[2][N].r.y;

			for (int j = 0; j < 4; j++) begin
				fa_s2[j] <= rnd30(fm_s1[j]);
			end
			cy_s2  <= cy_s1;
			sy2_s2 <= sy2_s1;

			fp_s3[0] <= mulw(fa_s2[0], cy_s2);
			fp_s3[1] <= mulw(fa_s2[1], sy2_s2);
			fp_s3[2] <= mulw(fa_s2[2], cy_s2);
			fp_s3[3] <= mulw(fa_s2[3], sy2_s2);
			fp_s3[4] <= mulw(fa_s2[3], cy_s2);
			fp_s3[5] <= mulw(fa_s2[2], sy2_s2);
			fp_s3[6] <= mulw(fa_s2[0], sy2_s2);
			fp_s3[7] <= mulw(fa_s2[1], cy_s2);

			for (int j = 0; j < 8; j++) begin
				fr_s4[j] <= rnd30(fp_s3[j]);
			end

			out_s5.q_w <= out_q(fr_s4[0] + fr_s4[1]);
			out_s5.q_x <= out_q(fr_s4[2] - fr_s4[3]);
			out_s5.q_y <= out_q(fr_s4[4] + fr_s4[5]);
			out_s5.q_z <= out_q(fr_s4[6] - fr_s4[7]);
		end
	end

endmodule

// ===== rtl/eucq_chk.sv =====
// Port-level checker for the Euler-to-quaternion top level, bound to it.
module eucq_chk import eucq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      angles_valid,
	input logic      angles_stall,
	input eucq_in_t  angles,
	input logic      quat_valid,
	input logic      quat_stall,
	input eucq_out_t quat
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && angles_stall |=> angles_valid && $stable(angles))
		else $error("stalled angle item changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat_stall |=> quat_valid && $stable(quat))
		else $error("stalled quaternion changed");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat_stall |-> angles_stall)
		else $error("input taken while output blocked");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!quat_valid |-> !angles_stall)
		else $error("input stalled with empty output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> quat.q_w >= -16'sd16384 && quat.q_w <= 16'sd16384 &&
			quat.q_x >= -16'sd16384 && quat.q_x <= 16'sd16384 &&
			quat.q_y >= -16'sd16384 && quat.q_y <= 16'sd16384 &&
			quat.q_z >= -16'sd16384 && quat.q_z <= 16'sd16384)
		else $error("quaternion component out of range");

endmodule

bind euler_convention_to_quaternion_top eucq_chk u_chk (.*);
